>>> rtl/core/assert_macros.svh
// assertion helpers shared by checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock, off during reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, off during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> rtl/core/sach_pkg.sv
package sach_pkg;

   localparam int MAX_WAYS   = 8;
   localparam int MAX_SETS   = 1024;
   localparam int ADDR_BITS  = 32;
   localparam int WAY_BITS   = $clog2(MAX_WAYS);
   localparam int SET_BITS   = $clog2(MAX_SETS);
   localparam int CFG_BITS   = 4;

   // register indexes
   localparam logic [2:0] REG_SPLIT    = 3'd0;
   localparam logic [2:0] REG_LINE     = 3'd1;
   localparam logic [2:0] REG_WAYS     = 3'd2;
   localparam logic [2:0] REG_DSETS    = 3'd3;
   localparam logic [2:0] REG_ISETS    = 3'd4;
   localparam logic [2:0] REG_POLICY   = 3'd5;
   localparam logic [2:0] REG_WALLOC   = 3'd6;
   localparam logic [2:0] REG_PREFETCH = 3'd7;

   // policy and access codes
   localparam logic [1:0] POL_LRU    = 2'd0;
   localparam logic [1:0] POL_FIFO   = 2'd1;
   localparam logic [1:0] POL_RANDOM = 2'd2;
   // spare policy code, acts as random
   localparam logic [1:0] POL_SPARE  = 2'd3;
   localparam logic [2:0] ACC_READ  = 3'd0;
   localparam logic [2:0] ACC_WRITE = 3'd1;
   localparam logic [2:0] ACC_FETCH = 3'd2;

   localparam logic [15:0] LFSR_SEED = 16'hACE1;
   localparam logic [15:0] LFSR_TAPS = 16'hB400;

   typedef struct packed {
      logic       split_mode;
      logic [3:0] line_size_log2;
      logic [1:0] ways_log2;
      logic [3:0] data_sets_log2;
      logic [3:0] instr_sets_log2;
      logic [1:0] replace_policy;
      logic       write_allocate;
      logic       prefetch_on_miss;
   } cfg_type;

   // one set: a line tag and a valid bit per way
   typedef struct packed {
      logic [MAX_WAYS-1:0]                valid;
      logic [MAX_WAYS-1:0][ADDR_BITS-1:0] lines;
   } set_type;

   // lookup request to the set memory unit
   typedef struct packed {
      logic                 use_instr;
      logic [SET_BITS-1:0]  set_index;
   } look_type;

endpackage

>>> rtl/core/sach_set_ram.sv
module sach_set_ram (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [sach_pkg::SET_BITS:0] rd_addr,
   output sach_pkg::set_type        rd_data,
   input  logic                     wr_en,
   input  logic [sach_pkg::SET_BITS:0] wr_addr,
   input  sach_pkg::set_type        wr_data
);
   import sach_pkg::*;

   // instruction sets above data sets; valid bits stored with the tags
   set_type mem [2*MAX_SETS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

>>> rtl/core/sach_update.sv
module sach_update (
   input  sach_pkg::set_type                 cur,
   input  logic [sach_pkg::ADDR_BITS-1:0]    la,
   input  logic [1:0]                        ways_log2,
   input  logic [1:0]                        policy,
   input  logic                              no_alloc,
   input  logic [sach_pkg::WAY_BITS-1:0]     rnd_pos,
   output logic                              hit,
   output logic                              write_back,
   output sach_pkg::set_type                 nxt
);
   import sach_pkg::*;

   logic [MAX_WAYS-1:0] in_use;
   logic [MAX_WAYS-1:0] match;
   logic [MAX_WAYS-1:0] above;
   logic [MAX_WAYS-1:0] empty;
   logic [WAY_BITS:0]   nways;
   logic [WAY_BITS-1:0] hit_way;
   logic [WAY_BITS-1:0] free_way;
   logic                any_free;
   logic [WAY_BITS:0]   dst;

   // ways in use and tag compare
   always_comb begin
      nways = (WAY_BITS+1)'(1) << ways_log2;
      for (int i = 0; i < MAX_WAYS; i++) begin
         in_use[i] = (i < int'(nways));
         match[i]  = in_use[i] && cur.valid[i] && (cur.lines[i] == la);
         empty[i]  = in_use[i] && !cur.valid[i];
      end
   end

   // lowest matching and lowest empty way
   always_comb begin
      hit_way  = '0;
      free_way = '0;
      for (int i = MAX_WAYS-1; i >= 0; i--) begin
         if (match[i]) hit_way = WAY_BITS'(i);
         if (empty[i]) free_way = WAY_BITS'(i);
      end
      hit      = |match;
      any_free = |empty;
   end

   // next set contents
   always_comb begin
      nxt        = cur;
      write_back = 1'b0;
      above      = '0;
      dst        = '0;
      if (hit) begin
         if (policy == POL_LRU) begin
            write_back = 1'b1;
            for (int i = 0; i < MAX_WAYS; i++) begin
               above[i] = in_use[i] && (i > int'(hit_way));
            end
            // compact valid lines above the hit, then the hit line
            dst = {1'b0, hit_way};
            for (int i = 0; i < MAX_WAYS; i++) begin
               if (above[i] && cur.valid[i]) begin
                  nxt.lines[dst[WAY_BITS-1:0]] = cur.lines[i];
                  nxt.valid[dst[WAY_BITS-1:0]] = 1'b1;
                  dst = dst + 1'b1;
               end
            end
            nxt.lines[dst[WAY_BITS-1:0]] = la;
            nxt.valid[dst[WAY_BITS-1:0]] = 1'b1;
            for (int i = 0; i < MAX_WAYS; i++) begin
               if (above[i] && (i > int'(dst))) nxt.valid[i] = 1'b0;
            end
         end
      end else if (!no_alloc) begin
         write_back = 1'b1;
         if (policy[1]) begin
            nxt.lines[rnd_pos] = la;
            nxt.valid[rnd_pos] = 1'b1;
         end else if (any_free) begin
            nxt.lines[free_way] = la;
            nxt.valid[free_way] = 1'b1;
         end else begin
            // drop way 0, shift down, new line on top
            for (int i = 0; i < MAX_WAYS-1; i++) begin
               if (in_use[i+1]) begin
                  nxt.lines[i] = cur.lines[i+1];
                  nxt.valid[i] = cur.valid[i+1];
               end
            end
            nxt.lines[nways[WAY_BITS-1:0] - 1'b1] = la;
            nxt.valid[nways[WAY_BITS-1:0] - 1'b1] = 1'b1;
         end
      end
   end
endmodule

>>> rtl/core/set_assoc_cache_hit_miss.sv
// channel   ports                                   direction
// request   start, busy, req_access_type, req_address  in
// result    rsp_valid, rsp_hit .. rsp_is_last          out, one-cycle strobe
// config    csr_write_en, csr_index, csr_write_data     in
// an access goes through read, then compare and write back, then a registered result;
// a miss with prefetch repeats these steps for the next line. The set memory reads synchronously.
// after reset a clearing pass writes every one of the 2048 sets once, with busy high.
// synchronous active-high reset; results cannot be held off.
module set_assoc_cache_hit_miss (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_access_type,
   input  logic [30:0] req_address,
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [3:0]  csr_write_data,
   output logic        rsp_valid,
   output logic        rsp_hit,
   output logic        rsp_is_prefetch,
   output logic [31:0] rsp_line_address,
   output logic [2:0]  rsp_access_kind,
   output logic        rsp_used_instr_cache,
   output logic        rsp_is_last
);
   import sach_pkg::*;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_MOD   = 3'd3;

   logic [2:0]           state_ff, state_in;
   logic [SET_BITS:0]    clr_ff, clr_in;
   cfg_type              cfg_ff, cfg_in;
   logic [15:0]          lfsr_ff, lfsr_in;
   logic [ADDR_BITS-1:0] la_ff, la_in;
   logic [2:0]           kind_ff, kind_in;
   logic                 instr_ff, instr_in;
   logic                 pf_ff, pf_in;
   look_type             look;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_hit_ff, rsp_pf_ff, rsp_last_ff, rsp_last_in;

   set_type              rd_data, nxt, clr_set;
   logic                 hit, write_back, wr_en;
   logic [SET_BITS:0]    addr;
   logic [ADDR_BITS-1:0] req_la, lsz;
   logic [3:0]           sl;
   logic [SET_BITS-1:0]  set_mask;
   logic [ADDR_BITS-1:0] line_num;
   logic [15:0]          lfsr_adv;
   logic [WAY_BITS-1:0]  rnd_pos;
   logic [WAY_BITS:0]    nways;

   // line address and set index
   always_comb begin
      lsz      = ADDR_BITS'(1) << cfg_ff.line_size_log2;
      req_la   = {1'b0, req_address} & ~(lsz - 1'b1);
      sl       = instr_ff ? cfg_ff.instr_sets_log2 : cfg_ff.data_sets_log2;
      if (sl > 4'(SET_BITS)) sl = 4'(SET_BITS);
      set_mask = SET_BITS'((32'd1 << sl) - 1);
      line_num = la_ff >> cfg_ff.line_size_log2;
      look.use_instr = instr_ff;
      look.set_index = line_num[SET_BITS-1:0] & set_mask;
      addr     = (state_ff == ST_CLEAR) ? clr_ff : {look.use_instr, look.set_index};
      clr_set  = '0;
   end

   // lfsr step and random way
   always_comb begin
      lfsr_adv = {1'b0, lfsr_ff[15:1]} ^ (lfsr_ff[0] ? LFSR_TAPS : 16'h0);
      nways    = (WAY_BITS+1)'(1) << cfg_ff.ways_log2;
      rnd_pos  = lfsr_adv[WAY_BITS-1:0] & (nways[WAY_BITS-1:0] - 1'b1);
   end

   sach_set_ram u_ram (
      .clock   (clock),
      .rd_en   (state_ff == ST_READ),
      .rd_addr (addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (addr),
      .wr_data ((state_ff == ST_CLEAR) ? clr_set : nxt)
   );

   sach_update u_upd (
      .cur        (rd_data),
      .la         (la_ff),
      .ways_log2  (cfg_ff.ways_log2),
      .policy     (cfg_ff.replace_policy),
      .no_alloc   ((kind_ff == ACC_WRITE) && !cfg_ff.write_allocate),
      .rnd_pos    (rnd_pos),
      .hit        (hit),
      .write_back (write_back),
      .nxt        (nxt)
   );

   assign wr_en = (state_ff == ST_CLEAR) || ((state_ff == ST_MOD) && write_back);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      lfsr_in      = lfsr_ff;
      la_in        = la_ff;
      kind_in      = kind_ff;
      instr_in     = instr_ff;
      pf_in        = pf_ff;
      rsp_valid_in = 1'b0;
      rsp_last_in  = 1'b1;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (&clr_ff) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               la_in    = req_la;
               kind_in  = req_access_type;
               instr_in = cfg_ff.split_mode && (req_access_type == ACC_FETCH);
               pf_in    = 1'b0;
               state_in = ST_READ;
            end
         end
         ST_READ: state_in = ST_MOD;
         ST_MOD: begin
            if (cfg_ff.replace_policy[1]) lfsr_in = lfsr_adv;
            rsp_valid_in = 1'b1;
            if (!hit && !pf_ff && cfg_ff.prefetch_on_miss) begin
               rsp_last_in = 1'b0;
               pf_in    = 1'b1;
               la_in    = la_ff + lsz;
               state_in = ST_READ;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // config writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            REG_SPLIT:    cfg_in.split_mode       = csr_write_data[0];
            REG_LINE:     cfg_in.line_size_log2   = csr_write_data;
            REG_WAYS:     cfg_in.ways_log2        = csr_write_data[1:0];
            REG_DSETS:    cfg_in.data_sets_log2   = csr_write_data;
            REG_ISETS:    cfg_in.instr_sets_log2  = csr_write_data;
            REG_POLICY:   cfg_in.replace_policy   = csr_write_data[1:0];
            REG_WALLOC:   cfg_in.write_allocate   = csr_write_data[0];
            REG_PREFETCH: cfg_in.prefetch_on_miss = csr_write_data[0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         lfsr_ff      <= LFSR_SEED;
         rsp_valid_ff <= 1'b0;
         cfg_ff       <= '{split_mode: 1'b0, line_size_log2: 4'd4, ways_log2: 2'd0,
                           data_sets_log2: 4'd6, instr_sets_log2: 4'd6,
                           replace_policy: POL_LRU, write_allocate: 1'b1,
                           prefetch_on_miss: 1'b0};
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         lfsr_ff      <= lfsr_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   // transaction payload
   always_ff @(posedge clock) begin
      la_ff    <= la_in;
      kind_ff  <= kind_in;
      instr_ff <= instr_in;
      pf_ff    <= pf_in;
      if (state_ff == ST_MOD) begin
         rsp_hit_ff       <= hit;
         rsp_pf_ff        <= pf_ff;
         rsp_last_ff      <= rsp_last_in;
         rsp_line_address <= la_ff;
         rsp_access_kind  <= kind_ff;
         rsp_used_instr_cache <= instr_ff;
      end
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_is_prefetch = rsp_pf_ff;
   assign rsp_is_last     = rsp_last_ff;
endmodule

>>> rtl/core/sach_checker.sv
`include "assert_macros.svh"
module sach_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic rsp_is_prefetch,
   input logic rsp_is_last
);
   // accepted transaction makes the block busy
   `ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy)
   // a prefetch result is always the last one
   `ASSERT_IMPL(a_pf_last, clock, reset, rsp_valid && rsp_is_prefetch, rsp_is_last)
   // a demand result that is not last is followed by a prefetch later, block stays busy
   `ASSERT_IMPL(a_more_busy, clock, reset, rsp_valid && !rsp_is_last, busy)
   // results never on consecutive cycles
   `ASSERT_NEXT(a_spaced, clock, reset, rsp_valid, !rsp_valid)
endmodule

bind set_assoc_cache_hit_miss sach_checker u_sach_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_is_prefetch(rsp_is_prefetch),
   .rsp_is_last(rsp_is_last)
);

>>> test/set_assoc_cache_hit_miss_tb.sv
module set_assoc_cache_hit_miss_tb;
   import sach_pkg::*;

   localparam int STORE_DEPTH = MAX_WAYS * MAX_SETS;
   localparam int STALL_LIMIT = 20000;
   localparam int N_PHASES    = 9;
   localparam int PHASE_ITEMS = 205;

   typedef struct {
      logic        hit;
      logic        is_prefetch;
      logic [31:0] line_address;
      logic [2:0]  access_kind;
      logic        used_instr_cache;
      logic        is_last;
   } lookup_result_type;

   typedef struct {
      logic [2:0]  kind;
      logic [30:0] addr;
      bit          typed;
      bit          hit;
   } access_row_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [2:0]  req_access_type;
   logic [30:0] req_address;
   logic        csr_write_en;
   logic [2:0]  csr_index;
   logic [3:0]  csr_write_data;
   logic        rsp_valid;
   logic        rsp_hit;
   logic        rsp_is_prefetch;
   logic [31:0] rsp_line_address;
   logic [2:0]  rsp_access_kind;
   logic        rsp_used_instr_cache;
   logic        rsp_is_last;

   // predictor state
   cfg_type     cfg;
   logic [31:0] dline [STORE_DEPTH];
   bit          dvalid [STORE_DEPTH];
   logic [31:0] iline [STORE_DEPTH];
   bit          ivalid [STORE_DEPTH];
   logic [15:0] lfsr;

   lookup_result_type pending_results[$];
   logic [30:0]    addr_pool[16];
   int errors, mismatches, stall_cycles;
   int n_items, n_results, n_hits, n_prefetch;
   int idle_pct;

   set_assoc_cache_hit_miss uut (.*);

   // clock
   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // lfsr advance
   function automatic logic [15:0] lfsr_advance();
      logic lsb;
      lsb = lfsr[0];
      lfsr = lfsr >> 1;
      if (lsb) lfsr = lfsr ^ LFSR_TAPS;
      return lfsr;
   endfunction

   // one set lookup, updates predictor tags
   function automatic bit cache_lookup(logic [31:0] la, bit use_i, bit is_wr);
      int nsets, ways, base, pos, dst;
      bit  found;
      bit  no_alloc;
      nsets = 1 << (use_i ? cfg.instr_sets_log2 : cfg.data_sets_log2);
      if (nsets > MAX_SETS) nsets = MAX_SETS;
      ways = 1 << cfg.ways_log2;
      base = ((la >> cfg.line_size_log2) % nsets) * MAX_WAYS;
      no_alloc = is_wr && !cfg.write_allocate;
      pos = 0;
      found = 0;
      if (cfg.replace_policy >= POL_RANDOM) pos = lfsr_advance() % ways;
      for (int i = 0; i < ways && !found; i++) begin
         if ((use_i ? ivalid[base+i] : dvalid[base+i]) &&
             (use_i ? iline[base+i] : dline[base+i]) == la) begin
            found = 1;
            if (cfg.replace_policy == POL_LRU) begin
               dst = i;
               for (int w = i + 1; w < ways; w++) begin
                  if (use_i ? ivalid[base+w] : dvalid[base+w]) begin
                     if (use_i) iline[base+dst] = iline[base+w];
                     else dline[base+dst] = dline[base+w];
                     dst++;
                  end
               end
               for (int w = i; w < ways; w++) begin
                  if (use_i) ivalid[base+w] = (w <= dst);
                  else dvalid[base+w] = (w <= dst);
               end
               if (use_i) iline[base+dst] = la;
               else dline[base+dst] = la;
            end
         end
      end
      if (found) return 1;
      if (no_alloc) return 0;
      if (cfg.replace_policy < POL_RANDOM) begin
         pos = -1;
         for (int i = 0; i < ways && pos < 0; i++)
            if (!(use_i ? ivalid[base+i] : dvalid[base+i])) pos = i;
         if (pos < 0) begin
            // full set: shift out the oldest way
            for (int w = 0; w + 1 < ways; w++) begin
               if (use_i) iline[base+w] = iline[base+w+1];
               else dline[base+w] = dline[base+w+1];
            end
            pos = ways - 1;
         end
      end
      if (use_i) begin
         iline[base+pos] = la;
         ivalid[base+pos] = 1;
      end else begin
         dline[base+pos] = la;
         dvalid[base+pos] = 1;
      end
      return 0;
   endfunction

   // expected results for one accepted transaction
   task automatic predict_access(logic [2:0] kind, logic [30:0] addr,
                                 bit typed, bit thit);
      lookup_result_type r;
      logic [31:0] lsz, la;
      bit use_i, is_wr, pf;
      lsz = 32'd1 << cfg.line_size_log2;
      la = {1'b0, addr} & ~(lsz - 32'd1);
      use_i = cfg.split_mode && kind == ACC_FETCH;
      is_wr = kind == ACC_WRITE;
      r.hit = cache_lookup(la, use_i, is_wr);
      if (typed) r.hit = thit;
      pf = !r.hit && cfg.prefetch_on_miss;
      r.is_prefetch = 0;
      r.line_address = la;
      r.access_kind = kind;
      r.used_instr_cache = use_i;
      r.is_last = !pf;
      pending_results.insert(pending_results.size(), r);
      if (pf) begin
         la = la + lsz;
         r.hit = cache_lookup(la, use_i, is_wr);
         r.is_prefetch = 1;
         r.line_address = la;
         r.is_last = 1;
         pending_results.insert(pending_results.size(), r);
      end
   endtask

   // drive one transaction and wait for acceptance
   task automatic send_access(logic [2:0] kind, logic [30:0] addr,
                              bit typed, bit thit);
      int gap;
      gap = 0;
      while ($urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_access_type <= kind;
      req_address <= addr;
      do @(posedge clock); while (busy);
      n_items++;
      predict_access(kind, addr, typed, thit);
   endtask

   // let the block drain before touching registers
   task automatic wait_idle();
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // write all registers in sequence
   task automatic write_cfg(cfg_type c);
      logic [2:0] idx[8];
      logic [3:0] val[8];
      idx = '{REG_SPLIT, REG_LINE, REG_WAYS, REG_DSETS, REG_ISETS,
              REG_POLICY, REG_WALLOC, REG_PREFETCH};
      val = '{4'(c.split_mode), c.line_size_log2, 4'(c.ways_log2), c.data_sets_log2,
              c.instr_sets_log2, 4'(c.replace_policy), 4'(c.write_allocate),
              4'(c.prefetch_on_miss)};
      for (int i = 0; i < 8; i++) begin
         csr_write_en <= 1'b1;
         csr_index <= idx[i];
         csr_write_data <= val[i];
         @(posedge clock);
      end
      csr_write_en <= 1'b0;
      cfg = c;
   endtask

   function automatic cfg_type random_cfg();
      cfg_type c;
      c.split_mode = 1'($urandom_range(1));
      c.line_size_log2 = ($urandom_range(9) == 0) ? 4'($urandom_range(15))
                                                  : 4'($urandom_range(8));
      c.ways_log2 = 2'($urandom_range(3));
      c.data_sets_log2 = ($urandom_range(7) == 0) ? 4'($urandom_range(15))
                                                  : 4'($urandom_range(4));
      c.instr_sets_log2 = ($urandom_range(7) == 0) ? 4'($urandom_range(15))
                                                   : 4'($urandom_range(4));
      c.replace_policy = 2'($urandom_range(3));
      c.write_allocate = 1'($urandom_range(1));
      c.prefetch_on_miss = 1'($urandom_range(1));
      return c;
   endfunction

   // random address: mostly near a small working set, some conflicts, some noise
   function automatic logic [30:0] pick_address();
      int sel, shift;
      logic [30:0] a;
      sel = $urandom_range(99);
      a = addr_pool[$urandom_range(15)];
      shift = cfg.line_size_log2;
      if (sel < 55)
         a = a + (31'($urandom_range(3)) << shift)
               + (31'($urandom) & ((31'd1 << shift) - 31'd1));
      else if (sel < 80)
         a = a ^ (31'($urandom_range(7)) << (shift + cfg.data_sets_log2));
      else
         a = 31'($urandom);
      return a;
   endfunction

   function automatic logic [2:0] pick_kind();
      int r;
      r = $urandom_range(99);
      if (r < 45) return ACC_READ;
      if (r < 65) return ACC_WRITE;
      if (r < 85) return ACC_FETCH;
      return 3'($urandom_range(3, 7));
   endfunction

   // result checking
   always @(posedge clock) begin
      lookup_result_type e;
      if (!reset && rsp_valid) begin
         n_results++;
         if (rsp_hit) n_hits++;
         if (rsp_is_prefetch) n_prefetch++;
         if (pending_results.size() == 0) begin
            errors++;
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result transaction: line %h", rsp_line_address);
         end else begin
            e = pending_results.pop_front();
            if (rsp_hit !== e.hit || rsp_is_prefetch !== e.is_prefetch ||
                rsp_line_address !== e.line_address ||
                rsp_access_kind !== e.access_kind ||
                rsp_used_instr_cache !== e.used_instr_cache ||
                rsp_is_last !== e.is_last) begin
               errors++;
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: exp hit %b pf %b line %h kind %0d icache %b last %b",
                     e.hit, e.is_prefetch, e.line_address, e.access_kind,
                     e.used_instr_cache, e.is_last);
                  $display("          got hit %b pf %b line %h kind %0d icache %b last %b",
                     rsp_hit, rsp_is_prefetch, rsp_line_address, rsp_access_kind,
                     rsp_used_instr_cache, rsp_is_last);
               end
            end
         end
      end
   end

   // watchdog on cycles with no transaction
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid)
         stall_cycles <= 0;
      else if (stall_cycles >= STALL_LIMIT) begin
         $display("set_assoc_cache_hit_miss test failed");
         $finish;
      end else
         stall_cycles <= stall_cycles + 1;
   end

   initial begin
      access_row_type rows[12];
      cfg_type c;
      // directed rows; hits typed in where the empty reset cache makes them obvious
      rows = '{
         '{ACC_READ,  31'h0000_0000, 1, 0},
         '{ACC_READ,  31'h0000_000F, 1, 1},
         '{ACC_WRITE, 31'h0000_0010, 1, 0},
         '{ACC_WRITE, 31'h0000_001C, 1, 1},
         '{ACC_FETCH, 31'h0000_0020, 1, 0},
         '{ACC_FETCH, 31'h0000_0020, 1, 1},
         '{3'd3,      31'h7FFF_FFFF, 1, 0},
         '{3'd4,      31'h7FFF_FFF0, 1, 1},
         '{3'd5,      31'h0000_0400, 1, 0},
         '{3'd7,      31'h0000_0000, 1, 0},
         '{3'd6,      31'h5555_5555, 0, 0},
         '{ACC_WRITE, 31'h2AAA_AAAA, 0, 0}};
      errors = 0; mismatches = 0; stall_cycles = 0;
      n_items = 0; n_results = 0; n_hits = 0; n_prefetch = 0;
      idle_pct = 14;
      start = 1'b0; req_access_type = '0; req_address = '0;
      csr_write_en = 1'b0; csr_index = '0; csr_write_data = '0;
      cfg = '{1'b0, 4'd4, 2'd0, 4'd6, 4'd6, POL_LRU, 1'b1, 1'b0};
      for (int i = 0; i < STORE_DEPTH; i++) begin
         dline[i] = '0; dvalid[i] = 0; iline[i] = '0; ivalid[i] = 0;
      end
      lfsr = LFSR_SEED;
      reset = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (busy) @(posedge clock);

      // directed: reset settings, then every option but line size (8) at its extreme
      for (int p = 0; p < 2; p++) begin
         if (p == 1) begin
            wait_idle();
            write_cfg('{1'b1, 4'd8, 2'd3, 4'd15, 4'd15, POL_SPARE, 1'b0, 1'b1});
         end
         foreach (rows[i])
            send_access(rows[i].kind, rows[i].addr, rows[i].typed && p == 0, rows[i].hit);
      end

      // random phases
      for (int ph = 0; ph < N_PHASES; ph++) begin
         idle_pct = (ph < 3) ? 14 : (ph < 6) ? 80 : 0;
         if (ph == 1) c = '{1'b0, 4'd0, 2'd0, 4'd0, 4'd0, POL_LRU, 1'b0, 1'b0};
         else if (ph == 4) c = '{1'b1, 4'd8, 2'd3, 4'd10, 4'd10, POL_RANDOM, 1'b1, 1'b1};
         else if (ph == 7) c = '{1'b1, 4'd15, 2'd3, 4'd15, 4'd15, POL_FIFO, 1'b0, 1'b1};
         else c = random_cfg();
         wait_idle();
         write_cfg(c);
         foreach (addr_pool[i]) addr_pool[i] = 31'($urandom);
         for (int i = 0; i < PHASE_ITEMS; i++)
            send_access(pick_kind(), pick_address(), 0, 0);
      end

      // drain
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("covered %0d accesses over %0d register settings, %0d results",
               n_items, N_PHASES + 2, n_results);
      $display("of which %0d hits and %0d next-line prefetch lookups", n_hits, n_prefetch);
      if (errors == 0)
         $display("set_assoc_cache_hit_miss test passed");
      else
         $display("set_assoc_cache_hit_miss test failed");
      $finish;
   end

endmodule
